FILE: rtl/lbld_pkg.sv
`default_nettype none
package lbld_pkg;

  // field and register widths
  localparam int SPEED_W  = 12;
  localparam int LEAN_W   = 11;
  localparam int GFORCE_W = 14;
  localparam int NOW_W    = 32;
  localparam int DIFF_W   = 14;
  localparam int MODE_W   = 3;
  localparam int LLIM_W   = 10;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAN_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAN_HIGH  = 3'd4;

  // register reset values
  localparam logic [SPEED_W-1:0] SPEED_HIGH_RST = 12'd2000;
  localparam logic [LLIM_W-1:0]  LEAN_HIGH_RST  = 10'd640;

  // fixed g-force range and update hold time
  localparam logic [DIFF_W-1:0] GFORCE_FULL_MG = 14'd5000;
  localparam int HOLD_MS = 50;

  // defaults for top level parameters
  localparam int BAR_LEDS_DEF   = 12;
  localparam int SHIFT_BITS_DEF = 16;

  // display modes
  typedef enum logic [MODE_W-1:0] {
    MODE_SPEED  = 3'd0,
    MODE_RPM    = 3'd1,
    MODE_LEAN   = 3'd2,
    MODE_GFORCE = 3'd3,
    MODE_CUSTOM = 3'd4,
    MODE_OFF    = 3'd5
  } lbld_mode_t;

  // top level sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_SCALE,
    ST_SHIFT
  } lbld_state_t;

endpackage
`default_nettype wire

FILE: rtl/lbld_if.sv
`default_nettype none
// telemetry sample channel
interface lbld_sample_if import lbld_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [SPEED_W-1:0]         speed_sample;
  logic signed [LEAN_W-1:0]   lean_sample;
  logic [GFORCE_W-1:0]        gforce_sample;
  logic [NOW_W-1:0]           now_ms;

  modport source (output valid, speed_sample, lean_sample, gforce_sample, now_ms,
                  input ready);
  modport sink (input valid, speed_sample, lean_sample, gforce_sample, now_ms,
                output ready);
endinterface

// serial bit channel
interface lbld_bit_if;
  logic valid;
  logic ready;
  logic serial_bit;
  logic latch_after;

  modport source (output valid, serial_bit, latch_after, input ready);
  modport sink (input valid, serial_bit, latch_after, output ready);
endinterface
`default_nettype wire

FILE: rtl/lbld_level_unit.sv
`default_nettype none
// level = min(floor(diff * BAR_LEDS / span), BAR_LEDS) by repeated add and compare
module lbld_level_unit import lbld_pkg::*; #(
  parameter int BAR_LEDS = BAR_LEDS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic                            zero,
  input  wire logic [DIFF_W-1:0]               diff,
  input  wire logic [DIFF_W-1:0]               span,
  output logic                                 done,
  output logic [$clog2(BAR_LEDS+1)-1:0]        level
);

  localparam int LVL_W = $clog2(BAR_LEDS + 1);
  localparam int NUM_W = DIFF_W + LVL_W;

  logic               busy;
  logic [LVL_W-1:0]   cnt;
  logic [NUM_W-1:0]   num;
  logic [NUM_W-1:0]   acc;
  logic [DIFF_W-1:0]  span_q;
  logic [NUM_W:0]     sum;

  // shared adder and compare
  assign sum = {1'b0, acc} + (NUM_W + 1)'(span_q);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= zero ? '0 : LVL_W'(BAR_LEDS);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - LVL_W'(1);
        end
      end
    end
  end

  // datapath: one step of the level search each cycle
  always_ff @(posedge clk) begin
    if (start) begin
      num    <= NUM_W'(diff) * NUM_W'(BAR_LEDS);
      acc    <= '0;
      span_q <= span;
      level  <= '0;
    end else if (busy && cnt != '0) begin
      if (sum <= {1'b0, num}) begin
        acc   <= sum[NUM_W-1:0];
        level <= level + LVL_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/led_bargraph_level_driver.sv
`default_nettype none
// LED bargraph level driver
// Samples arrive on the sample channel (speed, lean, g-force, ms timestamp).
// The display mode register picks one value, scaled to a bar level; its
// thermometer code becomes the goal pattern (RPM and custom keep the goal,
// off clears it). The shown pattern takes the goal only when HOLD_MS ms
// have passed since the last take. Each sample then produces SHIFT_BITS
// items on the bits channel: the shown pattern zero-extended, MSB first,
// with latch_after set on the last bit. Configuration is a write port
// (wr_en, wr_index, wr_data), to be written only while idle; the block
// itself does not enforce this. Steps per sample: the accept, a setup
// state, the level search in the shared add/compare unit, the pattern
// update, then one bit per cycle while the receiver is ready.
// When the value is at or below the low end or the range is empty the search
// skips its add/compare steps and gives level zero.
// The first bit is offered once the patterns have been updated.
// sample.ready is high only between samples.
// A stalled receiver holds the current bit; the block waits with it.
// Reset clears the patterns, the take timestamp and the registers to their
// reset values, and returns the block to waiting for a sample.
module led_bargraph_level_driver import lbld_pkg::*; #(
  parameter int BAR_LEDS   = BAR_LEDS_DEF,
  parameter int SHIFT_BITS = SHIFT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  lbld_sample_if.sink                sample,
  lbld_bit_if.source                 bits,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data
);

  localparam int LVL_W = $clog2(BAR_LEDS + 1);
  localparam int CNT_W = $clog2(SHIFT_BITS);

  lbld_state_t state, state_next;

  // configuration registers
  logic [MODE_W-1:0]  display_mode;
  logic [SPEED_W-1:0] speed_low;
  logic [SPEED_W-1:0] speed_high;
  logic [LLIM_W-1:0]  lean_low;
  logic [LLIM_W-1:0]  lean_high;

  // block state
  logic [BAR_LEDS-1:0]   shown_pattern;
  logic [BAR_LEDS-1:0]   goal_pattern;
  logic [NOW_W-1:0]      last_take_ms;

  // captured sample
  logic [DIFF_W-1:0]     val;
  logic [DIFF_W-1:0]     lo;
  logic [DIFF_W-1:0]     hi;
  logic [NOW_W-1:0]      now_q;

  logic [SHIFT_BITS-1:0] shift_reg;
  logic [CNT_W-1:0]      bit_cnt;

  logic [LEAN_W-1:0]     lean_raw;
  logic [LEAN_W-1:0]     lean_mag;
  logic [DIFF_W-1:0]     val_sel;
  logic [DIFF_W-1:0]     lo_sel;
  logic [DIFF_W-1:0]     hi_sel;

  logic                  unit_zero;
  logic [DIFF_W-1:0]     unit_diff;
  logic [DIFF_W-1:0]     span_w;
  logic                  unit_done;
  logic [LVL_W-1:0]      level;

  logic [BAR_LEDS-1:0]   therm;
  logic [BAR_LEDS-1:0]   goal_next;
  logic [BAR_LEDS-1:0]   shown_next;
  logic [NOW_W-1:0]      elapsed;
  logic                  take;
  logic [BAR_LEDS+SHIFT_BITS-1:0] pattern_ext;

  logic                  in_fire;
  logic                  out_fire;
  logic                  last_bit;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      display_mode <= MODE_SPEED;
      speed_low    <= '0;
      speed_high   <= SPEED_HIGH_RST;
      lean_low     <= '0;
      lean_high    <= LEAN_HIGH_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_MODE:       display_mode <= wr_data[MODE_W-1:0];
        CFG_SPEED_LOW:  speed_low    <= wr_data[SPEED_W-1:0];
        CFG_SPEED_HIGH: speed_high   <= wr_data[SPEED_W-1:0];
        CFG_LEAN_LOW:   lean_low     <= wr_data[LLIM_W-1:0];
        CFG_LEAN_HIGH:  lean_high    <= wr_data[LLIM_W-1:0];
        default: ;
      endcase
    end
  end

  // value and range select; lean uses its magnitude
  always_comb begin
    lean_raw = sample.lean_sample;
    lean_mag = lean_raw[LEAN_W-1] ? (~lean_raw + LEAN_W'(1)) : lean_raw;
    case (display_mode)
      MODE_LEAN: begin
        val_sel = DIFF_W'(lean_mag);
        lo_sel  = DIFF_W'(lean_low);
        hi_sel  = DIFF_W'(lean_high);
      end
      MODE_GFORCE: begin
        val_sel = DIFF_W'(sample.gforce_sample);
        lo_sel  = '0;
        hi_sel  = GFORCE_FULL_MG;
      end
      default: begin
        val_sel = DIFF_W'(sample.speed_sample);
        lo_sel  = DIFF_W'(speed_low);
        hi_sel  = DIFF_W'(speed_high);
      end
    endcase
  end

  assign in_fire  = sample.valid && sample.ready;
  assign out_fire = bits.valid && bits.ready;
  assign last_bit = (bit_cnt == CNT_W'(SHIFT_BITS - 1));

  // capture the sample
  always_ff @(posedge clk) begin
    if (in_fire) begin
      val   <= val_sel;
      lo    <= lo_sel;
      hi    <= hi_sel;
      now_q <= sample.now_ms;
    end
  end

  // operands for the level search; span is only used when positive
  always_comb begin
    span_w    = hi - lo;
    unit_diff = val - lo;
    unit_zero = (hi <= lo) || (val <= lo);
  end

  lbld_level_unit #(
    .BAR_LEDS (BAR_LEDS)
  ) u_level (
    .clk   (clk),
    .rst   (rst),
    .start (state == ST_PREP),
    .zero  (unit_zero),
    .diff  (unit_diff),
    .span  (span_w),
    .done  (unit_done),
    .level (level)
  );

  // goal and shown pattern update
  always_comb begin
    for (int i = 0; i < BAR_LEDS; i++) begin
      therm[i] = (level > LVL_W'(i));
    end
    case (display_mode)
      MODE_RPM, MODE_CUSTOM: goal_next = goal_pattern;
      MODE_OFF:              goal_next = '0;
      default:               goal_next = therm;
    endcase
    elapsed     = now_q - last_take_ms;
    take        = (elapsed >= NOW_W'(HOLD_MS));
    shown_next  = take ? goal_next : shown_pattern;
    pattern_ext = {{SHIFT_BITS{1'b0}}, shown_next};
  end

  // pattern state
  always_ff @(posedge clk) begin
    if (rst) begin
      shown_pattern <= '0;
      goal_pattern  <= '0;
      last_take_ms  <= '0;
    end else if (state == ST_SCALE && unit_done) begin
      goal_pattern  <= goal_next;
      shown_pattern <= shown_next;
      if (take) begin
        last_take_ms <= now_q;
      end
    end
  end

  // serial shifter
  always_ff @(posedge clk) begin
    if (state == ST_SCALE && unit_done) begin
      shift_reg <= pattern_ext[SHIFT_BITS-1:0];
    end else if (out_fire) begin
      shift_reg <= shift_reg << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt <= '0;
    end else if (state == ST_SCALE) begin
      bit_cnt <= '0;
    end else if (out_fire) begin
      bit_cnt <= bit_cnt + CNT_W'(1);
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer and handshakes
  always_comb begin
    state_next       = state;
    sample.ready     = 1'b0;
    bits.valid       = 1'b0;
    bits.serial_bit  = shift_reg[SHIFT_BITS-1];
    bits.latch_after = last_bit;
    case (state)
      ST_IDLE: begin
        sample.ready = 1'b1;
        if (sample.valid) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        if (unit_done) begin
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        bits.valid = 1'b1;
        if (bits.ready && last_bit) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
